/* sv/assert_macros.svh */
// Assertion macros shared by the coulomb counter RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WCC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wcc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WCC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wcc assertion failed");

`endif

/* sv/wcc_pkg.sv */
// Shared widths, codes and types of the windowed coulomb counter.
// Used by the channel interfaces and every RTL module; depends on nothing.
package wcc_pkg;

   // Item kinds carried in the func field.
   localparam logic [1:0] FuncSample = 2'd0;
   localparam logic [1:0] FuncTick   = 2'd1;
   localparam logic [1:0] FuncMsg    = 2'd2;

   // Configuration register indexes.
   localparam int         CsrIdxW     = 1;
   localparam logic [0:0] CsrGain     = 1'b0;
   localparam logic [0:0] CsrSetMsgId = 1'b1;
   localparam int         CsrDataW    = 29;

   // Field widths.
   localparam int FuncW   = 2;
   localparam int AdcW    = 10;
   localparam int MsgIdW  = 29;
   localparam int ByteW   = 8;
   localparam int OutW    = 16;
   localparam int GainW   = 24;
   localparam int GainFrac = 24;

   // Moving window of sample deltas.
   localparam int WindowLen = 100;
   localparam int DeltaW    = AdcW + 1;
   localparam int SumW      = $clog2(WindowLen * ((1 << AdcW) - 1) + 1) + 1;

   // Product of window sum and gain, and its magnitude.
   localparam int ProdW = SumW + GainW;
   localparam int MagW  = ProdW - 1;
   localparam int CurW  = MagW - GainFrac;

   // Capacity accumulator: 40 bits signed, 16 fraction bits.
   localparam int CapW    = 40;
   localparam int CapFrac = 16;

   // Increment = product / (3600 * 2^(24-16)) = product / (225 * 2^12).
   localparam int DivPow = 12;
   localparam int DivOdd = 225;
   localparam int XW     = MagW - DivPow;
   localparam int QW     = XW - 7;
   localparam int RecipK = XW + 8;
   localparam int RecipW = RecipK - 7;
   localparam logic [RecipW-1:0] RecipM =
      RecipW'(((longint'(1) << RecipK) + longint'(DivOdd - 1)) / longint'(DivOdd));

   localparam logic signed [CapW-1:0] CapMax = {1'b0, {(CapW-1){1'b1}}};
   localparam logic signed [CapW-1:0] CapMin = {1'b1, {(CapW-1){1'b0}}};

   // One job handed from the front end to the charge pipeline.
   typedef struct packed {
      logic                    tick;
      logic signed [ProdW-1:0] prod;
      logic [ByteW-1:0]        byte0;
   } wcc_job_type;

endpackage

/* sv/wcc_ifs.sv */
// Request and response channel interfaces of the coulomb counter.
// Depends on wcc_pkg for the field widths.
interface wcc_req_if
   import wcc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [FuncW-1:0]  func;
   logic [AdcW-1:0]   measured_adc;
   logic [AdcW-1:0]   reference_adc;
   logic [MsgIdW-1:0] msg_id;
   logic [ByteW-1:0]  msg_byte0;
   logic              msg_invalid;

   modport source (output valid, func, measured_adc, reference_adc, msg_id, msg_byte0,
                   msg_invalid, input ready);
   modport sink (input valid, func, measured_adc, reference_adc, msg_id, msg_byte0,
                 msg_invalid, output ready);
endinterface

interface wcc_rsp_if
   import wcc_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic signed [OutW-1:0] current_value;
   logic signed [OutW-1:0] capacity_value;

   modport source (output valid, current_value, capacity_value, input ready);
   modport sink (input valid, current_value, capacity_value, output ready);
endinterface

/* sv/wcc_cell.sv */
// One cell of the delta window: holds one sample delta.
// Depends on wcc_pkg.
module wcc_cell
   import wcc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift,
   input  logic signed [DeltaW-1:0] d_in,
   output logic signed [DeltaW-1:0] d_out
);

   logic signed [DeltaW-1:0] delta_ff;
   logic signed [DeltaW-1:0] delta_in;

   assign delta_in = shift ? d_in : delta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff <= '0;
      end else begin
         delta_ff <= delta_in;
      end
   end

   assign d_out = delta_ff;

endmodule

/* sv/wcc_window.sv */
// Row of delta cells and the running window sum.
// Depends on wcc_pkg and wcc_cell.
module wcc_window
   import wcc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     sample,
   input  logic signed [DeltaW-1:0] delta,
   output logic signed [SumW-1:0]   window_sum
);

   logic signed [DeltaW-1:0] tap [WindowLen];
   logic signed [SumW-1:0]   sum_ff;
   logic signed [SumW-1:0]   sum_in;
   logic signed [DeltaW-1:0] oldest;

   for (genvar i = 0; i < WindowLen; i++) begin : g_cell
      if (i == 0) begin : g_head
         wcc_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (sample),
            .d_in  (delta),
            .d_out (tap[i])
         );
      end else begin : g_body
         wcc_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (sample),
            .d_in  (tap[i-1]),
            .d_out (tap[i])
         );
      end
   end

   // The last cell holds the delta written one full window ago.
   assign oldest = tap[WindowLen-1];

   assign sum_in = sample
      ? sum_ff - {{(SumW-DeltaW){oldest[DeltaW-1]}}, oldest}
               + {{(SumW-DeltaW){delta[DeltaW-1]}}, delta}
      : sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign window_sum = sum_ff;

endmodule

/* sv/wcc_charge.sv */
// Charge pipeline: current scaling, hourly division, capacity accumulation, output.
// Depends on wcc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wcc_charge
   import wcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  wcc_job_type            in_job,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic signed [OutW-1:0] current_value,
   output logic signed [OutW-1:0] capacity_value
);

   // Truncated magnitude with sign, saturated to a signed 16-bit word.
   function automatic logic [OutW-1:0] sat_mag(input logic neg, input logic [CapW-1:0] mag);
      logic [CapW-1:0] pos_lim;
      logic [CapW-1:0] neg_lim;
      logic [OutW-1:0] low;
      pos_lim = CapW'((1 << (OutW-1)) - 1);
      neg_lim = CapW'(1 << (OutW-1));
      low     = mag[OutW-1:0];
      if (!neg) begin
         return (mag > pos_lim) ? {1'b0, {(OutW-1){1'b1}}} : low;
      end else begin
         return (mag > neg_lim) ? {1'b1, {(OutW-1){1'b0}}} : (~low + OutW'(1));
      end
   endfunction

   // Stage 1: product of window sum and gain.
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_tick_ff;
   logic signed [ProdW-1:0] s1_prod_ff;
   logic [ByteW-1:0]        s1_byte_ff;
   // Stage 2: sign, current word, magnitude scaled by 2^-12.
   logic                    s2_valid_ff, s2_valid_in;
   logic                    s2_tick_ff, s2_neg_ff;
   logic [OutW-1:0]         s2_cur_ff;
   logic [XW-1:0]           s2_x_ff;
   logic [ByteW-1:0]        s2_byte_ff;
   // Stage 3: quotient by 225.
   logic                    s3_valid_ff, s3_valid_in;
   logic                    s3_tick_ff, s3_neg_ff;
   logic [OutW-1:0]         s3_cur_ff;
   logic [QW-1:0]           s3_q_ff;
   logic [ByteW-1:0]        s3_byte_ff;
   // Stage 4: accumulator snapshot for a tick.
   logic                    s4_valid_ff, s4_valid_in;
   logic [OutW-1:0]         s4_cur_ff;
   logic signed [CapW-1:0]  s4_acc_ff;
   // Stage 5: result word.
   logic                    s5_valid_ff, s5_valid_in;
   logic [OutW-1:0]         s5_cur_ff;
   logic [OutW-1:0]         s5_cap_ff;

   logic signed [CapW-1:0]  acc_ff, acc_in;

   logic r1, r2, r3, r4, r5;
   logic load_go;

   logic [ProdW-1:0]        mag_full;
   logic [MagW-1:0]         mag;
   logic [XW+RecipW-1:0]    recip_prod;
   logic [CapW:0]           acc_ext, q_ext, acc_sum;
   logic signed [CapW-1:0]  acc_step;
   logic signed [CapW-1:0]  load_val;
   logic [CapW-1:0]         acc_mag;

   // Each stage moves when it is empty or the next one moves.
   assign r5 = !s5_valid_ff || out_ready;
   assign r4 = !s4_valid_ff || r5;
   assign r3 = !s3_valid_ff || r4;
   assign r2 = !s2_valid_ff || r3;
   assign r1 = !s1_valid_ff || r2;
   assign in_ready = r1;

   assign s1_valid_in = r1 ? in_valid : s1_valid_ff;
   assign s2_valid_in = r2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = r3 ? s2_valid_ff : s3_valid_ff;
   // Only ticks go on past the accumulator; loads finish there.
   assign s4_valid_in = r4 ? (s3_valid_ff && s3_tick_ff) : s4_valid_ff;
   assign s5_valid_in = r5 ? s4_valid_ff : s5_valid_ff;

   // Magnitude of the product; it always fits in MagW bits.
   assign mag_full = s1_prod_ff[ProdW-1] ? ProdW'(-s1_prod_ff) : ProdW'(s1_prod_ff);
   assign mag      = mag_full[MagW-1:0];

   // Reciprocal multiply: exact floor division by 225 for every XW-bit value,
   // since the rounding excess of the reciprocal times the operand stays below 2^RecipK.
   assign recip_prod = (XW+RecipW)'(s2_x_ff) * (XW+RecipW)'(RecipM);

   // Signed increment applied by add or subtract, then saturated to 40 bits.
   assign acc_ext  = {acc_ff[CapW-1], acc_ff};
   assign q_ext    = {{(CapW+1-QW){1'b0}}, s3_q_ff};
   assign acc_sum  = s3_neg_ff ? (acc_ext - q_ext) : (acc_ext + q_ext);
   assign acc_step = (acc_sum[CapW] != acc_sum[CapW-1])
      ? (acc_sum[CapW] ? CapMin : CapMax) : acc_sum[CapW-1:0];
   assign load_val = {{(CapW-CapFrac-ByteW){s3_byte_ff[ByteW-1]}}, s3_byte_ff,
                      {CapFrac{1'b0}}};

   assign load_go = s3_valid_ff && !s3_tick_ff && r4;

   always_comb begin
      acc_in = acc_ff;
      if (s3_valid_ff && r4) begin
         acc_in = s3_tick_ff ? acc_step : load_val;
      end
   end

   assign acc_mag = s4_acc_ff[CapW-1] ? CapW'(-s4_acc_ff) : CapW'(s4_acc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         s1_tick_ff <= in_job.tick;
         s1_prod_ff <= in_job.prod;
         s1_byte_ff <= in_job.byte0;
      end
      if (r2) begin
         s2_tick_ff <= s1_tick_ff;
         s2_neg_ff  <= s1_prod_ff[ProdW-1];
         s2_cur_ff  <= sat_mag(s1_prod_ff[ProdW-1], CapW'(mag[MagW-1:GainFrac]));
         s2_x_ff    <= mag[MagW-1:DivPow];
         s2_byte_ff <= s1_byte_ff;
      end
      if (r3) begin
         s3_tick_ff <= s2_tick_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_cur_ff  <= s2_cur_ff;
         s3_q_ff    <= recip_prod[RecipK +: QW];
         s3_byte_ff <= s2_byte_ff;
      end
      if (r4) begin
         s4_cur_ff <= s3_cur_ff;
         s4_acc_ff <= acc_step;
      end
      if (r5) begin
         s5_cur_ff <= s4_cur_ff;
         s5_cap_ff <= sat_mag(s4_acc_ff[CapW-1], CapW'(acc_mag[CapW-1:CapFrac]));
      end
   end

   assign out_valid      = s5_valid_ff;
   assign current_value  = s5_cur_ff;
   assign capacity_value = s5_cap_ff;

   `WCC_ASSERT_NEXT(a_load_whole_units, load_go, acc_ff[CapFrac-1:0] == '0)
   `WCC_ASSERT_NEXT(a_tick_reaches_output, s4_valid_ff && r5, s5_valid_ff)
   `WCC_ASSERT_NOW(a_positive_current, s2_valid_ff && !s2_neg_ff, !s2_cur_ff[OutW-1])

endmodule

/* sv/windowed_current_coulomb_counter.sv */
// Windowed current coulomb counter: top level with the register file and front end.
// Throughput is one word per cycle for every kind unless a waiting result stalls the
// input; a tick's result word passes through the five-stage charge pipeline.
// Samples and messages give no result; samples only update the cells and window sum.
// Synchronous active-high reset clears all cells, the window sum, the capacity and
// the pipeline, and loads the default gain and set-message identifier.
module windowed_current_coulomb_counter
   import wcc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   wcc_req_if.sink             req_ch,
   wcc_rsp_if.source           rsp_ch,
   input  logic                csr_write_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   // Configuration registers.
   logic [GainW-1:0]  gain_ff, gain_in;
   logic [MsgIdW-1:0] set_id_ff, set_id_in;

   logic                     accept;
   logic                     sample_go;
   logic                     tick_go;
   logic                     load_go;
   logic signed [DeltaW-1:0] delta;
   logic signed [SumW-1:0]   window_sum;
   logic signed [SumW+GainW:0] prod_full;
   wcc_job_type              job;
   logic                     job_ready;

   always_comb begin
      gain_in   = gain_ff;
      set_id_in = set_id_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CsrGain:     gain_in   = csr_wdata[GainW-1:0];
            CsrSetMsgId: set_id_in = csr_wdata[MsgIdW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GainW'(77770);
         set_id_ff <= MsgIdW'(32'h020000F2);
      end else begin
         gain_ff   <= gain_in;
         set_id_ff <= set_id_in;
      end
   end

   // A word is taken whenever the first pipeline stage can take a job. A result
   // that waits at the output stalls the input only once all five stages hold a job.
   assign req_ch.ready = job_ready;
   assign accept       = req_ch.valid && job_ready;

   assign sample_go = accept && (req_ch.func == FuncSample);
   assign tick_go   = accept && (req_ch.func == FuncTick);
   // A message loads capacity only when it is flagged valid and its identifier matches.
   assign load_go   = accept && (req_ch.func == FuncMsg) && !req_ch.msg_invalid
                      && (req_ch.msg_id == set_id_ff);

   assign delta = $signed({1'b0, req_ch.reference_adc}) - $signed({1'b0, req_ch.measured_adc});

   wcc_window u_window (
      .clock      (clock),
      .reset      (reset),
      .sample     (sample_go),
      .delta      (delta),
      .window_sum (window_sum)
   );

   // The window sum already holds every earlier sample, so the tick's product is
   // formed here, on the accepted word, and registered by the first stage.
   assign prod_full = window_sum * $signed({1'b0, gain_ff});

   always_comb begin
      job.tick  = tick_go;
      job.prod  = prod_full[ProdW-1:0];
      job.byte0 = req_ch.msg_byte0;
   end

   wcc_charge u_charge (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (tick_go || load_go),
      .in_ready       (job_ready),
      .in_job         (job),
      .out_valid      (rsp_ch.valid),
      .out_ready      (rsp_ch.ready),
      .current_value  (rsp_ch.current_value),
      .capacity_value (rsp_ch.capacity_value)
   );

endmodule
